// ===== rtl/core/q2e_pkg.sv =====
// shared types, constants and helper functions for the quaternion to euler converter
package q2e_pkg;

    localparam int QW = 32;
    localparam int AW = 64;
    localparam int DW = 36;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_READ_ERR = 2'd1;
    localparam logic [1:0] ST_NO_QUAT  = 2'd2;

    localparam logic signed [AW-1:0] ONE_Q30     = 64'sd1073741824;
    localparam logic signed [AW-1:0] HALF_PI_Q30 = 64'sd1686629713;
    localparam logic signed [AW-1:0] DEG_SCALE   = 64'sd5730;
    localparam logic signed [AW-1:0] ROUND_HALF  = 64'sd536870912;
    localparam logic signed [AW-1:0] LIM_PITCH   = 64'sd9000;
    localparam logic signed [AW-1:0] LIM_ANGLE   = 64'sd18000;

    // front to back queue entry
    typedef struct packed {
        logic [1:0]          status;
        logic signed [QW-1:0] w;
        logic signed [QW-1:0] x;
        logic signed [QW-1:0] y;
        logic signed [QW-1:0] z;
    } q2e_item_t;

    // result item
    typedef struct packed {
        logic [1:0]          status;
        logic signed [14:0]  pitch;
        logic signed [15:0]  roll;
        logic signed [15:0]  yaw;
    } q2e_res_t;

    // vectoring cordic lane state
    typedef struct packed {
        logic signed [AW-1:0] x;
        logic signed [AW-1:0] y;
        logic signed [AW-1:0] z;
        logic                 zero;
    } q2e_lane_t;

    // truncated atan(2^-i) in q.30 radians
    function automatic logic signed [AW-1:0] atan_entry(input logic [4:0] i);
        logic signed [AW-1:0] v;
        case (i)
            5'd0:  v = 64'sd843314856;
            5'd1:  v = 64'sd497837829;
            5'd2:  v = 64'sd263043836;
            5'd3:  v = 64'sd133525158;
            5'd4:  v = 64'sd67021686;
            5'd5:  v = 64'sd33543515;
            5'd6:  v = 64'sd16775850;
            5'd7:  v = 64'sd8388437;
            5'd8:  v = 64'sd4194282;
            5'd9:  v = 64'sd2097149;
            5'd10: v = 64'sd1048575;
            5'd11: v = 64'sd524287;
            5'd12: v = 64'sd262143;
            5'd13: v = 64'sd131071;
            5'd14: v = 64'sd65535;
            5'd15: v = 64'sd32767;
            5'd16: v = 64'sd16383;
            5'd17: v = 64'sd8191;
            5'd18: v = 64'sd4095;
            5'd19: v = 64'sd2047;
            5'd20: v = 64'sd1023;
            5'd21: v = 64'sd511;
            5'd22: v = 64'sd255;
            5'd23: v = 64'sd127;
            5'd24: v = 64'sd63;
            5'd25: v = 64'sd31;
            5'd26: v = 64'sd15;
            5'd27: v = 64'sd7;
            5'd28: v = 64'sd3;
            5'd29: v = 64'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

    // pre-rotation into the right half plane
    function automatic q2e_lane_t lane_init(input logic signed [AW-1:0] y,
                                            input logic signed [AW-1:0] x);
        q2e_lane_t l;
        l.zero = (x == 0) && (y == 0);
        l.x = x;
        l.y = y;
        l.z = '0;
        if (x < 0) begin
            if (y >= 0) begin
                l.x = y;
                l.y = -x;
                l.z = HALF_PI_Q30;
            end else begin
                l.x = -y;
                l.y = x;
                l.z = -HALF_PI_Q30;
            end
        end
        return l;
    endfunction

    // one micro-rotation of step i
    function automatic q2e_lane_t lane_step(input q2e_lane_t l, input logic [4:0] i);
        q2e_lane_t n;
        logic signed [AW-1:0] xs, ys;
        xs = l.x >>> i;
        ys = l.y >>> i;
        n = l;
        if (l.y >= 0) begin
            n.x = l.x + ys;
            n.y = l.y - xs;
            n.z = l.z + atan_entry(i);
        end else begin
            n.x = l.x - ys;
            n.y = l.y + xs;
            n.z = l.z - atan_entry(i);
        end
        return n;
    endfunction

    // clamp a scaled angle
    function automatic logic signed [AW-1:0] clamp(input logic signed [AW-1:0] a,
                                                   input logic signed [AW-1:0] lim);
        logic signed [AW-1:0] r;
        r = a;
        if (a > lim) r = lim;
        if (a < -lim) r = -lim;
        return r;
    endfunction

endpackage

// ===== rtl/core/quaternion_to_euler_angles.sv =====
// Quaternion (Q2.30) to z-y-x euler angles in 0.01 degree units. Takes one packet per
// clock cycle while the output is not stalled, and returns one result per packet, in order.
// A packet passes the input queue, CORDIC_STEPS + 39 pipeline stages (products, sums,
// s squared, radicand, a 32-stage bit-serial square root for the pitch cosine, lane setup,
// one stage per cordic iteration on three parallel lanes, two scaling stages) and the
// output register. Throughput is one transfer per cycle while m_tready does not stall it,
// set by the fully pipelined cordic and square root stages. Status 1 or 2 packets give zero angles.
module quaternion_to_euler_angles
    import q2e_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,  // quat_w, quat_x, quat_y, quat_z
    input  logic [1:0]   s_tuser,  // read_failed, has_quaternion
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [47:0]  m_tdata,  // pitch, roll, yaw, zero fill
    output logic [1:0]   m_tuser   // status
);

    q2e_item_t in_item, q_item;
    q2e_res_t  r_item;
    logic q_valid, q_ready;

    // packet unpack: status carries the two flags into the front
    assign in_item.status = s_tuser;
    assign in_item.w = s_tdata[31:0];
    assign in_item.x = s_tdata[63:32];
    assign in_item.y = s_tdata[95:64];
    assign in_item.z = s_tdata[127:96];

    q2e_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_item  (in_item),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item)
    );

    q2e_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_item  (q_item),
        .r_valid (m_tvalid),
        .r_ready (m_tready),
        .r_item  (r_item)
    );

    // result pack
    assign m_tuser = r_item.status;
    assign m_tdata = {1'b0, r_item.yaw, r_item.roll, r_item.pitch};

endmodule

// ===== rtl/core/q2e_front.sv =====
// input stage: classifies packets and writes them into a short queue
module q2e_front
    import q2e_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  q2e_item_t in_item,
    output logic      q_valid,
    input  logic      q_ready,
    output q2e_item_t q_item
);

    localparam int DEPTH = 4;

    q2e_item_t mem_reg [DEPTH];
    logic [1:0] wr_reg, wr_next, rd_reg, rd_next;
    logic [2:0] cnt_reg, cnt_next;
    logic push, pop;
    q2e_item_t cls;

    // status classification
    always_comb begin
        cls = in_item;
        if (in_item.status[0]) begin
            cls.status = ST_READ_ERR;
        end else if (!in_item.status[1]) begin
            cls.status = ST_NO_QUAT;
        end else begin
            cls.status = ST_OK;
        end
    end

    assign in_ready = (cnt_reg != 3'(DEPTH));
    assign q_valid  = (cnt_reg != 3'd0);
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;
    assign q_item   = mem_reg[rd_reg];

    // pointers and fill count
    always_comb begin
        wr_next  = push ? wr_reg + 2'd1 : wr_reg;
        rd_next  = pop ? rd_reg + 2'd1 : rd_reg;
        cnt_next = cnt_reg + {2'd0, push} - {2'd0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_reg] <= cls;
        end
    end

endmodule

// ===== rtl/core/q2e_back.sv =====
// compute pipeline: products, square root, three cordic lanes and scaling
module q2e_back
    import q2e_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      q_valid,
    output logic      q_ready,
    input  q2e_item_t q_item,
    output logic      r_valid,
    input  logic      r_ready,
    output q2e_res_t  r_item
);

    // stage map: 0 products, 1 sums, 2 s*s, 3 r, 4..35 sqrt, then cordic, then scale x2
    localparam int SQ_STEPS = 32;
    localparam int S_SQ0    = 4;
    localparam int S_COR0   = S_SQ0 + SQ_STEPS;
    localparam int S_MUL    = S_COR0 + CORDIC_STEPS + 1;
    localparam int NST      = S_MUL + 2;

    typedef struct packed {
        logic [1:0]           status;
        logic signed [AW-1:0] p0, p1, p2, p3, p4, p5, p6, p7;
        logic signed [AW-1:0] s;
        logic signed [AW-1:0] r;
        logic [AW-1:0]        sq_v;
        logic [AW-1:0]        sq_res;
        logic signed [AW-1:0] ry, rx, yy, yx;
        q2e_lane_t            lp, lr, lyw;
        logic signed [AW-1:0] ap, ar, ay;
    } q2e_stage_t;

    q2e_stage_t st_reg [NST];
    logic [NST-1:0] vld_reg;
    logic adv;
    q2e_res_t out_reg;
    logic out_vld_reg;

    // the whole pipe moves when the output register is free
    assign adv     = !out_vld_reg || r_ready;
    assign q_ready = adv;
    assign r_valid = out_vld_reg;
    assign r_item  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end else if (adv) begin
            vld_reg     <= {vld_reg[NST-2:0], q_valid};
            out_vld_reg <= vld_reg[NST-1];
        end
    end

    // products of the quaternion terms
    always_ff @(posedge aclk) begin
        q2e_stage_t n;
        n        = '0;
        n.status = q_item.status;
        n.p0     = (64'(q_item.w) * 64'(q_item.y)) >>> 30;
        n.p1     = (64'(q_item.x) * 64'(q_item.z)) >>> 30;
        n.p2     = (64'(q_item.y) * 64'(q_item.z)) >>> 30;
        n.p3     = (64'(q_item.w) * 64'(q_item.x)) >>> 30;
        n.p4     = (64'(q_item.x) * 64'(q_item.x)) >>> 30;
        n.p5     = (64'(q_item.y) * 64'(q_item.y)) >>> 30;
        n.p6     = (64'(q_item.x) * 64'(q_item.y)) >>> 30;
        n.p7     = (64'(q_item.w) * 64'(q_item.z)) >>> 30;
        n.sq_v   = 64'((64'(q_item.z) * 64'(q_item.z)) >>> 30);
        if (adv) begin
            st_reg[0] <= n;
        end
    end

    // sums, pitch argument saturation
    always_ff @(posedge aclk) begin
        q2e_stage_t n;
        logic signed [AW-1:0] s;
        n = st_reg[0];
        s = 64'sd2 * (st_reg[0].p0 - st_reg[0].p1);
        if (s > ONE_Q30) s = ONE_Q30;
        if (s < -ONE_Q30) s = -ONE_Q30;
        n.s  = s;
        n.ry = 64'sd2 * (st_reg[0].p2 + st_reg[0].p3);
        n.rx = ONE_Q30 - 64'sd2 * st_reg[0].p4 - 64'sd2 * st_reg[0].p5;
        n.yy = 64'sd2 * (st_reg[0].p6 + st_reg[0].p7);
        n.yx = ONE_Q30 - 64'sd2 * st_reg[0].p5 - 64'sd2 * $signed(st_reg[0].sq_v);
        if (adv) begin
            st_reg[1] <= n;
        end
    end

    // s squared, s fits in 32 signed bits after saturation
    always_ff @(posedge aclk) begin
        q2e_stage_t n;
        n   = st_reg[1];
        n.r = ($signed(st_reg[1].s[31:0]) * $signed(st_reg[1].s[31:0])) >>> 30;
        if (adv) begin
            st_reg[2] <= n;
        end
    end

    // radicand r * 2^30
    always_ff @(posedge aclk) begin
        q2e_stage_t n;
        logic signed [AW-1:0] r;
        n = st_reg[2];
        r = ONE_Q30 - st_reg[2].r;
        if (r < 0) r = '0;
        n.sq_v   = 64'(r) << 30;
        n.sq_res = '0;
        if (adv) begin
            st_reg[3] <= n;
        end
    end

    // bit-serial square root, one result bit per stage
    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
        localparam logic [AW-1:0] BIT = 64'd1 << (62 - 2 * k);
        always_ff @(posedge aclk) begin
            q2e_stage_t n;
            n = st_reg[S_SQ0+k-1];
            if (n.sq_v >= n.sq_res + BIT) begin
                n.sq_v   = n.sq_v - (n.sq_res + BIT);
                n.sq_res = (n.sq_res >> 1) + BIT;
            end else begin
                n.sq_res = n.sq_res >> 1;
            end
            if (adv) begin
                st_reg[S_SQ0+k] <= n;
            end
        end
    end

    // lane setup
    always_ff @(posedge aclk) begin
        q2e_stage_t n;
        n     = st_reg[S_COR0-1];
        n.lp  = lane_init(st_reg[S_COR0-1].s, $signed(st_reg[S_COR0-1].sq_res));
        n.lr  = lane_init(st_reg[S_COR0-1].ry, st_reg[S_COR0-1].rx);
        n.lyw = lane_init(st_reg[S_COR0-1].yy, st_reg[S_COR0-1].yx);
        if (adv) begin
            st_reg[S_COR0] <= n;
        end
    end

    // cordic iterations, one per stage
    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
        always_ff @(posedge aclk) begin
            q2e_stage_t n;
            n     = st_reg[S_COR0+k];
            n.lp  = lane_step(st_reg[S_COR0+k].lp, 5'(k));
            n.lr  = lane_step(st_reg[S_COR0+k].lr, 5'(k));
            n.lyw = lane_step(st_reg[S_COR0+k].lyw, 5'(k));
            if (adv) begin
                st_reg[S_COR0+k+1] <= n;
            end
        end
    end

    // degree scaling products
    always_ff @(posedge aclk) begin
        q2e_stage_t n;
        n    = st_reg[S_MUL-1];
        n.ap = st_reg[S_MUL-1].lp.zero ? 64'sd0
               : $signed(st_reg[S_MUL-1].lp.z[DW-1:0]) * DEG_SCALE;
        n.ar = st_reg[S_MUL-1].lr.zero ? 64'sd0
               : $signed(st_reg[S_MUL-1].lr.z[DW-1:0]) * DEG_SCALE;
        n.ay = st_reg[S_MUL-1].lyw.zero ? 64'sd0
               : $signed(st_reg[S_MUL-1].lyw.z[DW-1:0]) * DEG_SCALE;
        if (adv) begin
            st_reg[S_MUL] <= n;
        end
    end

    // rounding and saturation
    always_ff @(posedge aclk) begin
        q2e_stage_t n;
        n    = st_reg[S_MUL];
        n.ap = clamp((st_reg[S_MUL].ap + ROUND_HALF) >>> 30, LIM_PITCH);
        n.ar = clamp((st_reg[S_MUL].ar + ROUND_HALF) >>> 30, LIM_ANGLE);
        n.ay = clamp((st_reg[S_MUL].ay + ROUND_HALF) >>> 30, LIM_ANGLE);
        if (adv) begin
            st_reg[S_MUL+1] <= n;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (adv) begin
            out_reg.status <= st_reg[NST-1].status;
            if (st_reg[NST-1].status == ST_OK) begin
                out_reg.pitch <= st_reg[NST-1].ap[14:0];
                out_reg.roll  <= st_reg[NST-1].ar[15:0];
                out_reg.yaw   <= st_reg[NST-1].ay[15:0];
            end else begin
                out_reg.pitch <= '0;
                out_reg.roll  <= '0;
                out_reg.yaw   <= '0;
            end
        end
    end

endmodule
